>>> rtl/rapc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rapc_pkg;

  localparam int KEY_W       = 64;
  localparam int PIN_W       = 8;
  localparam int WORD_W      = 32;
  localparam int NWORDS      = 5;
  localparam int PRM_W       = WORD_W * NWORDS;
  localparam int ENT_W       = PIN_W + KEY_W;
  localparam int SLOT_W      = 6;
  localparam int DEF_ENTRIES = 16;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_NONE   = 3'd2,
    ST_REL    = 3'd3,
    ST_BADREL = 3'd4
  } status_e;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_REL_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] ent;
  } order_upd_t;

endpackage

`default_nettype wire

>>> rtl/readahead_param_mru_cache_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An acquire scans the key RAM in recency order, one entry per cycle; a release of a
//   slot beyond the pool skips the key RAM read and goes straight to the result.
// Throughput: one request at a time; the next is taken once the previous result
//   has been placed in the output register.
// Reset: recency list returns to 0..ENTRIES-1 and all valid bits clear, so every key,
//   pin count and parameter word reads as zero straight away; no clearing pass.
module readahead_param_mru_cache_unit
  import rapc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic [KEY_W-1:0]   file_key_i,
  input  wire logic [SLOT_W-1:0]  slot_in_i,
  input  wire logic [WORD_W-1:0]  reada_in_i,
  input  wire logic [WORD_W-1:0]  ramax_in_i,
  input  wire logic [WORD_W-1:0]  raend_in_i,
  input  wire logic [WORD_W-1:0]  ralen_in_i,
  input  wire logic [WORD_W-1:0]  rawin_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [2:0]         status_o,
  output logic      [SLOT_W-1:0]  slot_out_o,
  output logic      [WORD_W-1:0]  reada_out_o,
  output logic      [WORD_W-1:0]  ramax_out_o,
  output logic      [WORD_W-1:0]  raend_out_o,
  output logic      [WORD_W-1:0]  ralen_out_o,
  output logic      [WORD_W-1:0]  rawin_out_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_POS = IW'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [KEY_W-1:0]  key_q, key_d;
  logic [PRM_W-1:0]  words_q, words_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic              iss_done_q, iss_done_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IW-1:0]     chk_pos_q, chk_pos_d;
  logic [IW-1:0]     chk_ent_q, chk_ent_d;
  logic              free_vld_q, free_vld_d;
  logic [IW-1:0]     free_pos_q, free_pos_d;
  logic [IW-1:0]     free_ent_q, free_ent_d;
  logic [IW-1:0]     fnd_pos_q, fnd_pos_d;
  logic [IW-1:0]     ent_q, ent_d;
  logic [PIN_W-1:0]  pin_q, pin_d;
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [ENTRIES-1:0] ent_vld_q, ent_vld_d;
  logic [ENTRIES-1:0] prm_vld_q, prm_vld_d;

  logic              out_vld_q, out_vld_d;
  status_e           out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [PRM_W-1:0]  out_words_q, out_words_d;

  logic              ent_we, ent_re, prm_we, prm_re;
  logic [IW-1:0]     ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata, ent_cur;
  logic [PRM_W-1:0]  prm_rdata;
  logic [KEY_W-1:0]  cur_key;
  logic [PIN_W-1:0]  cur_pin;
  logic [PIN_W-1:0]  pin_new;
  logic [IW-1:0]     ord_ent;
  logic              in_acc, in_range, out_load, use_prm;
  order_upd_t        ord_upd;

  rapc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  rapc_ram #(
    .WIDTH (PRM_W),
    .DEPTH (ENTRIES)
  ) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (prm_we),
    .waddr_i (chk_ent_q),
    .wdata_i (words_q),
    .re_i    (prm_re),
    .raddr_i (ent_q),
    .rdata_o (prm_rdata)
  );

  rapc_order #(
    .ENTRIES (ENTRIES)
  ) u_order (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_pos_i (pos_q),
    .rd_ent_o (ord_ent),
    .upd_i    (ord_upd)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = {1'b0, slot_in_i} < (SLOT_W + 1)'(ENTRIES);
  assign ent_cur    = ent_vld_q[chk_ent_q] ? ent_rdata : '0;
  assign cur_key    = ent_cur[KEY_W-1:0];
  assign cur_pin    = ent_cur[KEY_W +: PIN_W];
  assign out_load   = (state_q == S_RESP) && (!out_vld_q || !out_stall_i);
  assign use_prm    = ((res_status_q == ST_HIT) || (res_status_q == ST_NEW))
                      && prm_vld_q[ent_q];

  always_comb begin
    if (res_status_q == ST_HIT) begin
      pin_new = (pin_q == PIN_MAX) ? pin_q : pin_q + PIN_W'(1);
    end else begin
      pin_new = PIN_W'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    words_d      = words_q;
    pos_d        = pos_q;
    iss_done_d   = iss_done_q;
    chk_vld_d    = 1'b0;
    chk_pos_d    = chk_pos_q;
    chk_ent_d    = chk_ent_q;
    free_vld_d   = free_vld_q;
    free_pos_d   = free_pos_q;
    free_ent_d   = free_ent_q;
    fnd_pos_d    = fnd_pos_q;
    ent_d        = ent_q;
    pin_d        = pin_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    ent_vld_d    = ent_vld_q;
    prm_vld_d    = prm_vld_q;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_waddr    = chk_ent_q;
    ent_raddr    = ord_ent;
    ent_wdata    = {cur_pin - PIN_W'(1), cur_key};
    prm_we       = 1'b0;
    prm_re       = 1'b0;
    ord_upd      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d      = file_key_i;
          words_d    = {reada_in_i, ramax_in_i, raend_in_i, ralen_in_i, rawin_in_i};
          res_slot_d = slot_in_i;
          if (command_i == CMD_ACQUIRE) begin
            pos_d      = '0;
            iss_done_d = 1'b0;
            free_vld_d = 1'b0;
            state_d    = S_SCAN;
          end else if (in_range) begin
            chk_ent_d = slot_in_i[IW-1:0];
            ent_re    = 1'b1;
            ent_raddr = slot_in_i[IW-1:0];
            state_d   = S_REL_CHK;
          end else begin
            res_status_d = ST_BADREL;
            state_d      = S_RESP;
          end
        end
      end

      S_SCAN: begin
        if (chk_vld_q && (cur_key == key_q)) begin
          fnd_pos_d    = chk_pos_q;
          ent_d        = chk_ent_q;
          pin_d        = cur_pin;
          res_status_d = ST_HIT;
          state_d      = S_UPDATE;
        end else if (chk_vld_q && (chk_pos_q == LAST_POS)) begin
          if (cur_pin == '0) begin
            fnd_pos_d    = chk_pos_q;
            ent_d        = chk_ent_q;
            res_status_d = ST_NEW;
            state_d      = S_UPDATE;
          end else if (free_vld_q) begin
            fnd_pos_d    = free_pos_q;
            ent_d        = free_ent_q;
            res_status_d = ST_NEW;
            state_d      = S_UPDATE;
          end else begin
            res_status_d = ST_NONE;
            res_slot_d   = '0;
            state_d      = S_RESP;
          end
        end else begin
          if (chk_vld_q && (cur_pin == '0)) begin
            free_vld_d = 1'b1;
            free_pos_d = chk_pos_q;
            free_ent_d = chk_ent_q;
          end
          if (!iss_done_q) begin
            ent_re    = 1'b1;
            chk_vld_d = 1'b1;
            chk_pos_d = pos_q;
            chk_ent_d = ord_ent;
            if (pos_q == LAST_POS) begin
              iss_done_d = 1'b1;
            end else begin
              pos_d = pos_q + IW'(1);
            end
          end
        end
      end

      S_UPDATE: begin
        ent_we           = 1'b1;
        ent_waddr        = ent_q;
        ent_wdata        = {pin_new, key_q};
        ent_vld_d[ent_q] = 1'b1;
        if (res_status_q == ST_NEW) begin
          prm_vld_d[ent_q] = 1'b0;
        end
        prm_re      = 1'b1;
        ord_upd.en  = 1'b1;
        ord_upd.pos = SLOT_W'(fnd_pos_q);
        ord_upd.ent = SLOT_W'(ent_q);
        res_slot_d  = SLOT_W'(ent_q);
        state_d     = S_RESP;
      end

      S_REL_CHK: begin
        if (cur_pin == '0) begin
          res_status_d = ST_BADREL;
        end else begin
          ent_we               = 1'b1;
          prm_we               = 1'b1;
          prm_vld_d[chk_ent_q] = 1'b1;
          res_status_d         = ST_REL;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_words_d  = out_words_q;
    if (out_load) begin
      out_vld_d    = 1'b1;
      out_status_d = res_status_q;
      out_slot_d   = res_slot_q;
      out_words_d  = use_prm ? prm_rdata : '0;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      iss_done_q <= 1'b0;
      chk_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      ent_vld_q  <= '0;
      prm_vld_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_done_q <= iss_done_d;
      chk_vld_q  <= chk_vld_d;
      free_vld_q <= free_vld_d;
      ent_vld_q  <= ent_vld_d;
      prm_vld_q  <= prm_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    words_q      <= words_d;
    pos_q        <= pos_d;
    chk_pos_q    <= chk_pos_d;
    chk_ent_q    <= chk_ent_d;
    free_pos_q   <= free_pos_d;
    free_ent_q   <= free_ent_d;
    fnd_pos_q    <= fnd_pos_d;
    ent_q        <= ent_d;
    pin_q        <= pin_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_words_q  <= out_words_d;
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign slot_out_o  = out_slot_q;
  assign reada_out_o = out_words_q[4*WORD_W +: WORD_W];
  assign ramax_out_o = out_words_q[3*WORD_W +: WORD_W];
  assign raend_out_o = out_words_q[2*WORD_W +: WORD_W];
  assign ralen_out_o = out_words_q[1*WORD_W +: WORD_W];
  assign rawin_out_o = out_words_q[0 +: WORD_W];

  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted request did not start");

  a_scan_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && iss_done_q) |-> chk_vld_q)
    else $error("scan stalled with no read in flight");

  a_pin_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> (pin_new != '0))
    else $error("acquired entry left unpinned");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_RESP))
    else $error("result loaded outside response state");

endmodule

`default_nettype wire

>>> rtl/rapc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rapc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rapc_order.sv
`timescale 1ns / 1ps
`default_nettype none

module rapc_order
  import rapc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_pos_i,
  output logic      [$clog2(ENTRIES)-1:0] rd_ent_o,
  input  wire order_upd_t                 upd_i
);

  localparam int IW = $clog2(ENTRIES);

  logic [IW-1:0] order_q [ENTRIES];
  logic [IW-1:0] order_d [ENTRIES];
  logic [IW-1:0] upd_pos;
  logic [IW-1:0] upd_ent;

  assign upd_pos  = upd_i.pos[IW-1:0];
  assign upd_ent  = upd_i.ent[IW-1:0];
  assign rd_ent_o = order_q[rd_pos_i];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      order_d[i] = order_q[i];
    end
    if (upd_i.en) begin
      order_d[0] = upd_ent;
      for (int i = 1; i < ENTRIES; i++) begin
        if (i <= int'(upd_pos)) begin
          order_d[i] = order_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        order_q[i] <= IW'(i);
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        order_q[i] <= order_d[i];
      end
    end
  end

endmodule

`default_nettype wire
